// ===== hw/rtl/brf_pkg.sv =====
package brf_pkg;

	localparam int CAP_CFG_W = 11;
	localparam int CNT_W     = 7;
	localparam int BYTE_W    = 8;

	typedef enum logic [2:0] {
		FUNC_PUSH  = 3'd0,
		FUNC_PEEK  = 3'd1,
		FUNC_POP   = 3'd2,
		FUNC_RDPOP = 3'd3,
		FUNC_CLEAR = 3'd4
	} func_t;

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic take;     // input request accepted this cycle
		logic rd_load;  // load next read byte into the output register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free; // output register empty or being drained
		logic rd_start; // current request is a read with at least one byte
		logic rd_last;  // one read byte left to deliver
	} stat_t;

endpackage

// ===== hw/rtl/brf_ram.sv =====
module brf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/brf_ctrl.sv =====
module brf_ctrl
	import brf_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  s_tvalid,
	output logic  s_tready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid && stat.out_free && stat.rd_start) begin
					state_n = ST_READ;
				end
			end
			ST_READ: begin
				if (stat.out_free && stat.rd_last) begin
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready    = 1'b0;
		cmd.take    = 1'b0;
		cmd.rd_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = stat.out_free;
				cmd.take = s_tvalid && stat.out_free;
			end
			ST_READ: begin
				cmd.rd_load = stat.out_free;
			end
			default: ;
		endcase
	end

endmodule

// ===== hw/rtl/brf_dpath.sv =====
module brf_dpath
	import brf_pkg::*;
#(
	parameter int DEPTH     = 1024,
	parameter int MAX_BURST = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CAP_CFG_W-1:0] cfg_wdata,
	input  logic [15:0]          s_tdata,
	input  logic [2:0]           s_tuser,
	input  logic                 s_tlast,
	input  logic                 m_tready,
	input  cmd_t                 cmd,
	output stat_t                stat,
	output logic                 m_tvalid,
	output logic [31:0]          m_tdata,
	output logic                 m_tuser,
	output logic                 m_tlast
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CAP_W = $clog2(DEPTH + 1);
	localparam int SUM_W = CAP_W + 1;
	localparam logic [CNT_W-1:0] MAX_B = CNT_W'(MAX_BURST);

	// queue state
	logic [PTR_W-1:0] wp_q, rp_q, raddr_q;
	logic [CAP_W-1:0] cap_q, free_q;
	logic             act_q, rej_q;
	logic [CNT_W-1:0] left_q, done_q, rem_q, n_q;

	// output register
	logic              m_valid_q;
	logic [BYTE_W-1:0] o_data_q;
	logic              o_dv_q, o_last_q, o_acc_q, o_empty_q, o_full_q;
	logic [CNT_W-1:0]  o_moved_q;
	logic [CAP_CFG_W-1:0] o_free_q;

	logic [PTR_W-1:0] wp_n, rp_n;
	logic [CAP_W-1:0] free_n, stored, cap_cfg;
	logic             act_n, rej_n;
	logic [CNT_W-1:0] left_n, done_n, n_sel, cnt;
	logic [SUM_W-1:0] rp_add, rp_inc, ra_inc, wp_inc;
	logic             ram_we, ram_re;
	logic [PTR_W-1:0] ram_raddr;
	logic [BYTE_W-1:0] ram_rdata, in_byte;
	logic             res_acc;
	logic [CNT_W-1:0] res_moved;
	func_t            func;

	assign func    = func_t'(s_tuser);
	assign in_byte = s_tdata[7:0];
	assign cnt     = s_tdata[14:8];
	assign stored  = cap_q - free_q;

	always_comb begin
		if (SUM_W'(cnt) > SUM_W'(stored)) begin
			n_sel = CNT_W'(stored);
		end else begin
			n_sel = cnt;
		end
		if (n_sel > MAX_B) begin
			n_sel = MAX_B;
		end
	end

	// pointer sums stay below twice the capacity: one compare and subtract wraps them
	assign rp_add = SUM_W'(rp_q) + SUM_W'(n_sel);
	assign rp_inc = SUM_W'(rp_q) + SUM_W'(1);
	assign ra_inc = SUM_W'(raddr_q) + SUM_W'(1);
	assign wp_inc = SUM_W'(wp_q) + SUM_W'(1);

	always_comb begin
		if (cfg_wdata == '0) begin
			cap_cfg = CAP_W'(1);
		end else if (32'(cfg_wdata) > DEPTH) begin
			cap_cfg = CAP_W'(DEPTH);
		end else begin
			cap_cfg = CAP_W'(cfg_wdata);
		end
	end

	always_comb begin
		wp_n      = wp_q;
		rp_n      = rp_q;
		free_n    = free_q;
		act_n     = 1'b0;
		rej_n     = rej_q;
		left_n    = left_q;
		done_n    = done_q;
		ram_we    = 1'b0;
		res_acc   = 1'b1;
		res_moved = '0;
		case (func)
			FUNC_PUSH: begin
				act_n = !s_tlast;
				if (!act_q) begin
					done_n = '0;
					rej_n  = (cnt > MAX_B) || (SUM_W'(cnt) > SUM_W'(free_q));
					left_n = rej_n ? '0 : cnt;
				end
				if (!rej_n && left_n != '0 && free_q != '0) begin
					ram_we = cmd.take;
					wp_n   = (wp_inc == SUM_W'(cap_q)) ? '0 : PTR_W'(wp_inc);
					free_n = free_q - CAP_W'(1);
					left_n = left_n - CNT_W'(1);
					done_n = done_n + CNT_W'(1);
				end
				res_acc   = !rej_n;
				res_moved = done_n;
			end
			FUNC_POP, FUNC_RDPOP: begin
				rp_n      = (rp_add >= SUM_W'(cap_q)) ? PTR_W'(rp_add - SUM_W'(cap_q))
				                                      : PTR_W'(rp_add);
				free_n    = free_q + CAP_W'(n_sel);
				res_moved = (func == FUNC_POP) ? n_sel : '0;
			end
			FUNC_CLEAR: begin
				wp_n   = '0;
				rp_n   = '0;
				free_n = cap_q;
				rej_n  = 1'b0;
				left_n = '0;
				done_n = '0;
			end
			default: ;
		endcase
	end

	assign stat.out_free = !m_valid_q || m_tready;
	assign stat.rd_start = (func == FUNC_PEEK || func == FUNC_RDPOP) && n_sel != '0;
	assign stat.rd_last  = rem_q == CNT_W'(1);

	assign ram_re    = (cmd.take && stat.rd_start) || (cmd.rd_load && !stat.rd_last);
	assign ram_raddr = cmd.take ? rp_q : raddr_q;

	brf_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wp_q),
		.wdata (in_byte),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			rp_q      <= '0;
			cap_q     <= CAP_W'(DEPTH);
			free_q    <= CAP_W'(DEPTH);
			act_q     <= 1'b0;
			rej_q     <= 1'b0;
			left_q    <= '0;
			done_q    <= '0;
			rem_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q  <= cap_cfg;
				free_q <= cap_cfg;
				wp_q   <= '0;
				rp_q   <= '0;
				act_q  <= 1'b0;
				rej_q  <= 1'b0;
				left_q <= '0;
				done_q <= '0;
			end else if (cmd.take) begin
				wp_q   <= wp_n;
				rp_q   <= rp_n;
				free_q <= free_n;
				act_q  <= act_n;
				rej_q  <= rej_n;
				left_q <= left_n;
				done_q <= done_n;
				if (stat.rd_start) begin
					rem_q <= n_sel;
				end
			end else if (cmd.rd_load) begin
				rem_q <= rem_q - CNT_W'(1);
			end

			if ((cmd.take && !stat.rd_start) || cmd.rd_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// read address walker and output payload
	always_ff @(posedge clk) begin
		if (cmd.take && stat.rd_start) begin
			raddr_q <= (rp_inc == SUM_W'(cap_q)) ? '0 : PTR_W'(rp_inc);
			n_q     <= n_sel;
		end else if (cmd.rd_load && !stat.rd_last) begin
			raddr_q <= (ra_inc == SUM_W'(cap_q)) ? '0 : PTR_W'(ra_inc);
		end

		if (cmd.take && !stat.rd_start) begin
			o_data_q  <= '0;
			o_dv_q    <= 1'b0;
			o_last_q  <= 1'b1;
			o_moved_q <= res_moved;
			o_acc_q   <= res_acc;
			o_free_q  <= CAP_CFG_W'(free_n);
			o_empty_q <= free_n == cap_q;
			o_full_q  <= free_n == '0;
		end else if (cmd.rd_load) begin
			o_data_q  <= ram_rdata;
			o_dv_q    <= 1'b1;
			o_last_q  <= stat.rd_last;
			o_moved_q <= n_q;
			o_acc_q   <= 1'b1;
			o_free_q  <= CAP_CFG_W'(free_q);
			o_empty_q <= free_q == cap_q;
			o_full_q  <= free_q == '0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {3'b000, o_full_q, o_empty_q, o_free_q, o_acc_q, o_moved_q, o_data_q};
	assign m_tuser  = o_dv_q;
	assign m_tlast  = o_last_q;

endmodule

// ===== hw/rtl/byte_ring_fifo_core.sv =====
// Channel   Dir  tdata (low bit up)                         tuser       tlast
// s_        in   data_byte[7:0] count[14:8]                 func[2:0]   last_byte
// m_        out  data_out[7:0] moved_count[14:8]            data_valid  last
//                accepted[15] free_count[26:16]
//                empty_res[27] full_res[28]
// cfg_      in   cfg_wdata = capacity, written when cfg_we is high
//
// Push, pop, clear and unused selectors: one request per cycle.
// Peek and read-pop of n bytes: one byte per cycle after the accept cycle while
// m_ takes them, paced by the registered read port of the storage RAM.
// Reset empties the queue and sets capacity to DEPTH; storage is not cleared.
// A stalled result on m_ holds s_tready low until it is taken.
module byte_ring_fifo_core
	import brf_pkg::*;
#(
	parameter int DEPTH     = 1024,
	parameter int MAX_BURST = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CAP_CFG_W-1:0] cfg_wdata,  // capacity
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [15:0]          s_tdata,    // data_byte, count
	input  logic [2:0]           s_tuser,    // func
	input  logic                 s_tlast,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [31:0]          m_tdata,    // data_out, moved_count, accepted,
	                                         // free_count, empty_res, full_res
	output logic                 m_tuser,    // data_valid
	output logic                 m_tlast
);

	cmd_t  cmd;
	stat_t stat;

	brf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	brf_dpath #(
		.DEPTH     (DEPTH),
		.MAX_BURST (MAX_BURST)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tready  (m_tready),
		.cmd       (cmd),
		.stat      (stat),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

// ===== hw/rtl/brf_checker.sv =====
module brf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled result changed");

	// no new request while a result waits
	a_backpress: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid || m_tready)
		else $error("request taken over a stalled result");

	a_empty_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[27] && m_tdata[28]))
		else $error("queue reported empty and full");

	// only read bytes come in multi-result runs
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast && m_tdata[7:0] == 8'd0)
		else $error("status result without tlast or with data");

endmodule

bind byte_ring_fifo_core brf_checker u_brf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
